### hw/rtl/bclru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_pkg
// Shared types and codes of the buffer cache tag store and free list.
// ----------------------------------------------------------------------------
package bclru_pkg;

  localparam logic [15:0] NO_DEVICE = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_GET     = 3'd0,
    ACT_LOOKUP  = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_RELDW   = 3'd3,
    ACT_IODONE  = 3'd4,
    ACT_FLUSH   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_BUSY      = 3'd2,
    ST_NOFREE    = 3'd3,
    ST_WRITEBACK = 3'd4,
    ST_BADDEV    = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  typedef struct packed {
    logic busy;
    logic wanted;
    logic done;
    logic error;
    logic delwri;
    logic async;
  } flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  // Per-cell command issued by the controller during the update cycle
  typedef struct packed {
    logic   write_tag;
    logic   write_flags;
    flags_t flags;
    logic   clear_dev;
  } cell_cmd_t;

endpackage

### hw/rtl/bclru_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_req_if / bclru_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface bclru_req_if #(parameter int BLOCK_BITS = 24, parameter int IDX_W = 4);
  logic                  valid;
  logic                  ready;
  logic [2:0]            action;
  logic [15:0]           device;
  logic [BLOCK_BITS-1:0] block;
  logic [IDX_W-1:0]      buffer_index;
  logic                  io_error;
  modport source (output valid, action, device, block, buffer_index, io_error,
                  input ready);
  modport sink   (input valid, action, device, block, buffer_index, io_error,
                  output ready);
endinterface

interface bclru_rsp_if #(parameter int BLOCK_BITS = 24, parameter int IDX_W = 4);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [IDX_W-1:0]      result_index;
  logic                  data_valid;
  logic [15:0]           victim_device;
  logic [BLOCK_BITS-1:0] victim_block;
  logic                  wake_buffer;
  logic                  wake_free;
  modport source (output valid, status, result_index, data_valid, victim_device,
                  victim_block, wake_buffer, wake_free, input ready);
  modport sink   (input valid, status, result_index, data_valid, victim_device,
                  victim_block, wake_buffer, wake_free, output ready);
endinterface

### hw/rtl/buffer_cache_lru_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_cache_lru_manager
// Associative tag store with a least-recently-released free list.
// ----------------------------------------------------------------------------
// Flow: a request beat is captured, then compared and applied to the cells
//   in a single compare/update pass (S_SCAN); the result register holds the
//   beat (S_OUT) until taken, and no new request is taken before that.
// Reset: synchronous active low; tags go to no device, flags clear, free
//   list 0..N-1 in order, device_count zero.
module buffer_cache_lru_manager
  import bclru_pkg::*;
#(
  parameter int NUM_BUFFERS = 16,
  parameter int BLOCK_BITS  = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  bclru_req_if.sink  in_ch,
  bclru_rsp_if.source out_ch
);
  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

  state_t state_r, state_nxt;
  logic [7:0] devcnt_r;

  // latched request
  logic [2:0]            act_r;
  logic [15:0]           dev_r;
  logic [BLOCK_BITS-1:0] blk_r;
  logic [IDX_W-1:0]      bi_r;
  logic                  ioerr_r;

  // free list
  logic [IDX_W-1:0] fo   [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] fo_shift, fo_load;
  logic [CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic fwant_r, fwant_nxt;

  // cells
  logic [NUM_BUFFERS-1:0] match;
  logic [15:0]           cdev [NUM_BUFFERS];
  logic [BLOCK_BITS-1:0] cblk [NUM_BUFFERS];
  flags_t                cfl  [NUM_BUFFERS];
  cell_cmd_t             ccmd [NUM_BUFFERS];

  // output register
  logic [2:0]            o_st_r;
  logic [IDX_W-1:0]      o_idx_r;
  logic                  o_dv_r, o_wb_r, o_wf_r;
  logic [15:0]           o_vd_r;
  logic [BLOCK_BITS-1:0] o_vb_r;

  genvar g;
  generate
    for (g = 0; g < NUM_BUFFERS; g++) begin : g_cell
      bclru_cell #(.BLOCK_BITS(BLOCK_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .cmp_dev(dev_r), .cmp_blk(blk_r),
        .cmd(ccmd[g]), .match(match[g]), .dev_o(cdev[g]), .blk_o(cblk[g]),
        .flags_o(cfl[g])
      );
    end
  endgenerate

  // --- update decision (combinational over the cell compares) ---
  logic [IDX_W-1:0] tgt, app_idx;
  logic             do_rem, do_app, tgt_ok;
  logic [2:0]       st;
  logic             dv, wb, wf;
  logic [CNT_W-1:0] rem_pos;
  flags_t           nf;
  logic             wr_tag, clr_dev;
  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic             fl_found;
  logic [IDX_W-1:0] fl_idx;
  logic             bad_major;

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
    if (dev_r == NO_DEVICE) hit_any = 1'b0;
    fl_found = 1'b0;
    fl_idx   = '0;
    for (int p = NUM_BUFFERS - 1; p >= 0; p--) begin
      if (CNT_W'(p) < fcnt_r && cfl[fo[p]].delwri &&
          (dev_r == NO_DEVICE || cdev[fo[p]] == dev_r)) begin
        fl_found = 1'b1;
        fl_idx   = fo[p];
      end
    end
  end

  // position of an index within the valid free list
  function automatic logic [CNT_W:0] find_pos(
    input logic [IDX_W-1:0] fo_a [NUM_BUFFERS], input logic [CNT_W-1:0] cnt,
    input logic [IDX_W-1:0] idx);
    logic [CNT_W:0] r;
    r = {1'b1, {CNT_W{1'b0}}};
    for (int p = NUM_BUFFERS - 1; p >= 0; p--) begin
      if (CNT_W'(p) < cnt && fo_a[p] == idx) r = {1'b0, CNT_W'(p)};
    end
    return r;
  endfunction

  logic [CNT_W:0] pos_tgt;

  always_comb begin
    st = ST_NONE; dv = 1'b0; wb = 1'b0; wf = 1'b0;
    tgt = '0; tgt_ok = 1'b0; do_rem = 1'b0; do_app = 1'b0;
    nf = '0; wr_tag = 1'b0; clr_dev = 1'b0;
    fwant_nxt = fwant_r;
    bad_major = dev_r[15:8] >= devcnt_r;
    unique case (act_r) inside
      ACT_GET: begin
        if (dev_r != NO_DEVICE && bad_major) begin
          st = ST_BADDEV;
        end else if (hit_any) begin
          tgt = hit_idx; tgt_ok = 1'b1;
          nf = cfl[hit_idx];
          if (nf.busy) begin
            nf.wanted = 1'b1; st = ST_BUSY;
          end else begin
            nf.busy = 1'b1; do_rem = 1'b1; st = ST_HIT;
          end
          dv = nf.done;
        end else if (fcnt_r == '0) begin
          fwant_nxt = 1'b1; st = ST_NOFREE;
        end else begin
          tgt = fo[0]; tgt_ok = 1'b1; do_rem = 1'b1;
          nf = cfl[fo[0]];
          if (nf.delwri) begin
            nf.busy = 1'b1; nf.async = 1'b1;
            nf.done = 1'b0; nf.error = 1'b0; nf.delwri = 1'b0;
            st = ST_WRITEBACK;
          end else begin
            nf = '0; nf.busy = 1'b1; wr_tag = 1'b1; st = ST_MISS;
          end
        end
      end
      ACT_LOOKUP: begin
        if (!bad_major && hit_any) begin
          st = ST_HIT; tgt = hit_idx; dv = cfl[hit_idx].done;
        end
      end
      ACT_FLUSH: begin
        if (fl_found) begin
          tgt = fl_idx; tgt_ok = 1'b1; do_rem = 1'b1;
          nf = cfl[fl_idx];
          nf.busy = 1'b1; nf.async = 1'b1;
          nf.done = 1'b0; nf.error = 1'b0; nf.delwri = 1'b0;
          st = ST_WRITEBACK;
        end
      end
      ACT_RELEASE, ACT_RELDW, ACT_IODONE: begin
        if (32'(bi_r) < NUM_BUFFERS) begin
          tgt = bi_r; tgt_ok = 1'b1;
          nf = cfl[bi_r];
          if (act_r == ACT_RELDW) begin
            nf.delwri = 1'b1; nf.done = 1'b1;
          end
          if (act_r == ACT_IODONE) begin
            nf.done = 1'b1;
            if (ioerr_r) nf.error = 1'b1;
          end
          if (act_r == ACT_IODONE && !nf.async) begin
            nf.wanted = 1'b0; wb = 1'b1;
          end else begin
            wb = nf.wanted; wf = fwant_r; fwant_nxt = 1'b0;
            clr_dev = nf.error;
            nf.wanted = 1'b0; nf.busy = 1'b0; nf.async = 1'b0;
            do_app = 1'b1;
          end
          dv = nf.done;
        end else begin
          tgt_ok = 1'b0;
        end
      end
      default: ;
    endcase
    if (act_r == ACT_LOOKUP || st == ST_NONE || st == ST_BADDEV ||
        st == ST_NOFREE) begin
      tgt_ok = (st == ST_NONE && (act_r == ACT_RELEASE || act_r == ACT_RELDW ||
                act_r == ACT_IODONE)) ? tgt_ok : 1'b0;
    end
    app_idx = tgt;
  end

  assign pos_tgt = find_pos(fo, fcnt_r, tgt);

  // free list shift control: remove at pos, optionally append at new tail
  always_comb begin
    logic           present;
    logic [CNT_W-1:0] cnt_rm;
    present  = !pos_tgt[CNT_W];
    rem_pos  = pos_tgt[CNT_W-1:0];
    fo_shift = '0;
    fo_load  = '0;
    fcnt_nxt = fcnt_r;
    cnt_rm   = fcnt_r;
    if (state_r == S_SCAN && tgt_ok && (do_rem || do_app) && present) begin
      for (int p = 0; p < NUM_BUFFERS; p++)
        if (CNT_W'(p) >= rem_pos && CNT_W'(p) + 1'b1 < fcnt_r) fo_shift[p] = 1'b1;
      cnt_rm = fcnt_r - 1'b1;
    end
    if (state_r == S_SCAN && tgt_ok && (do_rem || do_app)) fcnt_nxt = cnt_rm;
    if (state_r == S_SCAN && tgt_ok && do_app) begin
      for (int p = 0; p < NUM_BUFFERS; p++)
        if (CNT_W'(p) == cnt_rm) fo_load[p] = 1'b1;
      fcnt_nxt = cnt_rm + 1'b1;
    end
  end

  generate
    for (g = 0; g < NUM_BUFFERS; g++) begin : g_lru
      logic [IDX_W-1:0] nbr;
      if (g == NUM_BUFFERS - 1) begin : g_last
        assign nbr = fo[g];
      end else begin : g_mid
        assign nbr = fo[g + 1];
      end
      bclru_lru_cell #(.IDX_W(IDX_W)) u_lru (
        .clk(clk), .rst_n(rst_n), .rst_val(IDX_W'(g)), .shift(fo_shift[g]),
        .load(fo_load[g]), .nbr(nbr), .app(app_idx), .q(fo[g])
      );
      always_comb begin
        ccmd[g] = '0;
        if (state_r == S_SCAN && tgt_ok && tgt == IDX_W'(g)) begin
          ccmd[g].write_flags = 1'b1;
          ccmd[g].flags       = nf;
          ccmd[g].write_tag   = wr_tag;
          ccmd[g].clear_dev   = clr_dev;
        end
      end
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_SCAN;
      S_SCAN: state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = (state_r == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      devcnt_r <= '0;
      fcnt_r   <= CNT_W'(NUM_BUFFERS);
      fwant_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) devcnt_r <= cfg_wdata;
      if (state_r == S_SCAN) begin
        fcnt_r  <= fcnt_nxt;
        fwant_r <= fwant_nxt;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      act_r   <= in_ch.action;
      dev_r   <= in_ch.device;
      blk_r   <= in_ch.block;
      bi_r    <= in_ch.buffer_index;
      ioerr_r <= in_ch.io_error;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) begin
      o_st_r  <= st;
      o_idx_r <= (st == ST_NONE && !(act_r == ACT_RELEASE || act_r == ACT_RELDW ||
                  act_r == ACT_IODONE)) || st == ST_BADDEV || st == ST_NOFREE ||
                 (st == ST_NONE && !tgt_ok) ? '0 : tgt;
      o_dv_r  <= dv;
      o_wb_r  <= wb;
      o_wf_r  <= wf;
      o_vd_r  <= (st == ST_WRITEBACK) ? cdev[tgt] : 16'd0;
      o_vb_r  <= (st == ST_WRITEBACK) ? cblk[tgt] : '0;
    end
  end

  assign out_ch.status        = o_st_r;
  assign out_ch.result_index  = o_idx_r;
  assign out_ch.data_valid    = o_dv_r;
  assign out_ch.victim_device = o_vd_r;
  assign out_ch.victim_block  = o_vb_r;
  assign out_ch.wake_buffer   = o_wb_r;
  assign out_ch.wake_free     = o_wf_r;
endmodule

### hw/rtl/bclru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_cell
// One buffer slot: tags, flags and a local tag compare.
// ----------------------------------------------------------------------------
module bclru_cell
  import bclru_pkg::*;
#(
  parameter int BLOCK_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           cmp_dev,
  input  logic [BLOCK_BITS-1:0] cmp_blk,
  input  cell_cmd_t             cmd,
  output logic                  match,
  output logic [15:0]           dev_o,
  output logic [BLOCK_BITS-1:0] blk_o,
  output flags_t                flags_o
);
  logic [15:0]           dev_r;
  logic [BLOCK_BITS-1:0] blk_r;
  flags_t                flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= NO_DEVICE;
      blk_r   <= '0;
      flags_r <= '0;
    end else begin
      if (cmd.write_tag) begin
        dev_r <= cmp_dev;
        blk_r <= cmp_blk;
      end else if (cmd.clear_dev) begin
        dev_r <= NO_DEVICE;
      end
      if (cmd.write_flags) flags_r <= cmd.flags;
    end
  end

  assign match   = (dev_r == cmp_dev) && (blk_r == cmp_blk);
  assign dev_o   = dev_r;
  assign blk_o   = blk_r;
  assign flags_o = flags_r;
endmodule

### hw/rtl/bclru_lru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_lru_cell
// One slot of the free list shift chain; removal shifts in from the right.
// ----------------------------------------------------------------------------
module bclru_lru_cell #(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rst_val,
  input  logic             shift,   // take neighbor's entry
  input  logic             load,    // take appended entry
  input  logic [IDX_W-1:0] nbr,
  input  logic [IDX_W-1:0] app,
  output logic [IDX_W-1:0] q
);
  logic [IDX_W-1:0] q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= rst_val;
    end else if (load) begin
      q_r <= app;
    end else if (shift) begin
      q_r <= nbr;
    end
  end
  assign q = q_r;
endmodule

### hw/rtl/bclru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_sva
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
module bclru_sva
  import bclru_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status
);
  // a beat taken gives a result after its scan state
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid) else $error("result late");
  // no new request while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready)) else $error("overlap");
  // stalled result holds status
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  // status codes stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NONE) else $error("bad status");
endmodule

bind buffer_cache_lru_manager bclru_sva u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status)
);

### tb/bclru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_checker
// Passive scoreboard for the buffer cache tag store. It watches the config
// port and both channels, predicts each result beat from its own copy of the
// tags, flags and free list, and compares every field of each result beat.
// ----------------------------------------------------------------------------
module bclru_checker
  import bclru_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  bclru_req_if       req,
  bclru_rsp_if       rsp,
  output int         errors,
  output int         pending
);

  localparam int NBUF = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  index;
    logic        data_valid;
    logic [15:0] victim_device;
    logic [23:0] victim_block;
    logic        wake_buffer;
    logic        wake_free;
  } cache_beat_t;

  logic [7:0]  dev_count;
  logic [15:0] tag_dev [NBUF];
  logic [23:0] tag_blk [NBUF];
  flags_t      flg     [NBUF];
  int          lru_list[$];
  logic        want_any;
  cache_beat_t expected_beats[$];

  function automatic void lru_drop(int idx);
    for (int p = lru_list.size() - 1; p >= 0; p--)
      if (lru_list[p] == idx) lru_list.delete(p);
  endfunction

  function automatic int match_tag(logic [15:0] dev, logic [23:0] blk);
    if (dev == NO_DEVICE) return -1;
    for (int i = 0; i < NBUF; i++)
      if (tag_dev[i] == dev && tag_blk[i] == blk) return i;
    return -1;
  endfunction

  // Hand a dirty free buffer out for write-back
  function automatic void claim_dirty(int v, ref cache_beat_t r);
    lru_drop(v);
    flg[v].busy   = 1'b1;
    flg[v].async  = 1'b1;
    flg[v].done   = 1'b0;
    flg[v].error  = 1'b0;
    flg[v].delwri = 1'b0;
    r.status        = ST_WRITEBACK;
    r.index         = v[3:0];
    r.data_valid    = 1'b0;
    r.victim_device = tag_dev[v];
    r.victim_block  = tag_blk[v];
  endfunction

  function automatic void put_back(int i, ref cache_beat_t r);
    r.wake_buffer = flg[i].wanted;
    r.wake_free   = want_any;
    want_any      = 1'b0;
    if (flg[i].error) tag_dev[i] = NO_DEVICE;
    flg[i].wanted = 1'b0;
    flg[i].busy   = 1'b0;
    flg[i].async  = 1'b0;
    lru_drop(i);
    lru_list.push_back(i);
  endfunction

  function automatic cache_beat_t cache_outcome(logic [2:0] act, logic [15:0] dev,
                                                logic [23:0] blk, logic [3:0] bi,
                                                logic ioerr);
    cache_beat_t r;
    int          h;
    int          v;
    r = '0;
    r.status = ST_NONE;
    case (act)
      ACT_GET: begin
        if (dev != NO_DEVICE && dev[15:8] >= dev_count) begin
          r.status = ST_BADDEV;
          return r;
        end
        h = match_tag(dev, blk);
        if (h >= 0) begin
          r.index = h[3:0];
          if (flg[h].busy) begin
            flg[h].wanted = 1'b1;
            r.status = ST_BUSY;
          end else begin
            lru_drop(h);
            flg[h].busy = 1'b1;
            r.status = ST_HIT;
          end
          r.data_valid = flg[h].done;
          return r;
        end
        if (lru_list.size() == 0) begin
          want_any = 1'b1;
          r.status = ST_NOFREE;
          return r;
        end
        v = lru_list[0];
        if (flg[v].delwri) begin
          claim_dirty(v, r);
          return r;
        end
        lru_drop(v);
        flg[v]      = '0;
        flg[v].busy = 1'b1;
        tag_dev[v]  = dev;
        tag_blk[v]  = blk;
        r.status    = ST_MISS;
        r.index     = v[3:0];
      end
      ACT_LOOKUP: begin
        if (dev[15:8] >= dev_count) return r;
        h = match_tag(dev, blk);
        if (h >= 0) begin
          r.status     = ST_HIT;
          r.index      = h[3:0];
          r.data_valid = flg[h].done;
        end
      end
      ACT_FLUSH: begin
        foreach (lru_list[p]) begin
          v = lru_list[p];
          if (flg[v].delwri && (dev == NO_DEVICE || tag_dev[v] == dev)) begin
            claim_dirty(v, r);
            return r;
          end
        end
      end
      ACT_RELEASE, ACT_RELDW, ACT_IODONE: begin
        r.index = bi;
        if (act == ACT_RELDW) begin
          flg[bi].delwri = 1'b1;
          flg[bi].done   = 1'b1;
        end
        if (act == ACT_IODONE) begin
          flg[bi].done = 1'b1;
          if (ioerr) flg[bi].error = 1'b1;
          if (flg[bi].async) begin
            put_back(bi, r);
          end else begin
            flg[bi].wanted = 1'b0;
            r.wake_buffer  = 1'b1;
          end
        end else begin
          put_back(bi, r);
        end
        r.data_valid = flg[bi].done;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cache_beat_t got;
    cache_beat_t exp_b;
    if (!rst_n) begin
      dev_count = '0;
      lru_list.delete();
      for (int i = 0; i < NBUF; i++) begin
        tag_dev[i] = NO_DEVICE;
        tag_blk[i] = '0;
        flg[i]     = '0;
        lru_list.push_back(i);
      end
      want_any = 1'b0;
      expected_beats.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) dev_count = cfg_wdata;
      // result beat against the oldest expectation
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.result_index, rsp.data_valid, rsp.victim_device,
                rsp.victim_block, rsp.wake_buffer, rsp.wake_free};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_b = expected_beats.pop_front();
          if (got !== exp_b) begin
            $display("%0t: mismatch expected st=%0d idx=%0d dv=%0b vdev=%h vblk=%h wb=%0b wf=%0b",
                     $time, exp_b.status, exp_b.index, exp_b.data_valid,
                     exp_b.victim_device, exp_b.victim_block, exp_b.wake_buffer,
                     exp_b.wake_free);
            $display("%0t:          actual   st=%0d idx=%0d dv=%0b vdev=%h vblk=%h wb=%0b wf=%0b",
                     $time, got.status, got.index, got.data_valid, got.victim_device,
                     got.victim_block, got.wake_buffer, got.wake_free);
            errors <= errors + 1;
          end
        end
      end
      // request beat
      if (req.valid && req.ready)
        expected_beats.push_back(cache_outcome(req.action, req.device, req.block,
                                               req.buffer_index, req.io_error));
      pending <= expected_beats.size();
    end
  end

endmodule

### tb/buffer_cache_lru_manager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_cache_lru_manager_tb
// Stimulus and verdict for the buffer cache tag store: directed corner beats,
// then random get/lookup/release/io-done/flush traffic over several device
// counts with random stalls on both sides. Checking is done by bclru_checker.
// ----------------------------------------------------------------------------
module buffer_cache_lru_manager_tb;
  import bclru_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         errors;
  int         pending;
  bit         quiet;
  bit         long_hold;
  int         n_items;
  int         n_cfg;
  logic [7:0] dev_counts [5] = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd5};

  bclru_req_if #(24, 4) in_ch ();
  bclru_rsp_if #(24, 4) out_ch ();

  buffer_cache_lru_manager #(.NUM_BUFFERS(16), .BLOCK_BITS(24)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  bclru_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(in_ch), .rsp(out_ch), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    bit v;
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        v = 1'b1; n = 1;
      end else if (long_hold) begin
        v = 1'b0; n = 300;
        long_hold = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        v = 1'b0; n = $urandom_range(1, 10);
      end else begin
        v = 1'b1; n = $urandom_range(1, 20);
      end
      out_ch.ready <= v;
      repeat (n - 1) @(posedge clk);
    end
  end

  // One request beat; returns at the edge where it was taken
  task automatic send(logic [2:0] act, logic [15:0] dev, logic [23:0] blk,
                      logic [3:0] bi, logic ioerr);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.device       <= dev;
    in_ch.block        <= blk;
    in_ch.buffer_index <= bi;
    in_ch.io_error     <= ioerr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
  endtask

  // pending is registered, so it trails the beat just taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_majors(logic [7:0] cnt);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_beat();
    logic [2:0]  act;
    logic [15:0] dev;
    logic [23:0] blk;
    int          r;
    r = $urandom_range(0, 99);
    if      (r < 35) act = ACT_GET;
    else if (r < 45) act = ACT_LOOKUP;
    else if (r < 65) act = ACT_RELEASE;
    else if (r < 77) act = ACT_RELDW;
    else if (r < 90) act = ACT_IODONE;
    else if (r < 97) act = ACT_FLUSH;
    else             act = 3'($urandom_range(6, 7));
    r = $urandom_range(0, 9);
    if (r < 8)       dev = {8'($urandom_range(0, 4)), 8'($urandom_range(0, 2))};
    else if (r == 8) dev = 16'($urandom);
    else             dev = NO_DEVICE;
    blk = ($urandom_range(0, 7) != 0) ? 24'($urandom_range(0, 7)) : 24'($urandom);
    send(act, dev, blk, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 3) == 0));
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_GET;
    in_ch.device       = NO_DEVICE;
    in_ch.block        = '0;
    in_ch.buffer_index = '0;
    in_ch.io_error     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    quiet     = 1'b0;
    long_hold = 1'b0;
    n_items   = 0;
    n_cfg     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners of each action
    set_majors(8'd4);
    send(ACT_GET,     NO_DEVICE, 24'd0,        4'd0,  1'b0);  // no-device get
    send(ACT_GET,     16'h0100,  24'd5,        4'd0,  1'b0);  // miss
    send(ACT_GET,     16'h0100,  24'd5,        4'd0,  1'b0);  // busy -> wanted
    send(ACT_LOOKUP,  16'h0100,  24'd5,        4'd0,  1'b0);
    send(ACT_LOOKUP,  16'h0100,  24'd6,        4'd0,  1'b0);
    send(ACT_LOOKUP,  NO_DEVICE, 24'd0,        4'd0,  1'b0);
    send(ACT_RELEASE, 16'h0000,  24'd0,        4'd1,  1'b0);  // wakes waiter
    send(ACT_GET,     16'h0100,  24'd5,        4'd0,  1'b0);  // hit
    send(ACT_RELDW,   16'h0000,  24'd0,        4'd1,  1'b0);
    send(ACT_GET,     16'h03FF,  24'hFFFFFF,   4'd0,  1'b0);
    send(ACT_IODONE,  16'h0000,  24'd0,        4'd2,  1'b1);  // error on sync buf
    send(ACT_RELEASE, 16'h0000,  24'd0,        4'd2,  1'b0);  // drops device tag
    send(ACT_RELEASE, 16'h0000,  24'd0,        4'd15, 1'b0);  // already free
    send(ACT_FLUSH,   16'h0200,  24'd0,        4'd0,  1'b0);  // none on device
    send(ACT_FLUSH,   NO_DEVICE, 24'd0,        4'd0,  1'b0);  // async write-back
    send(ACT_IODONE,  16'h0000,  24'd0,        4'd1,  1'b0);  // auto release
    send(ACT_GET,     16'h0400,  24'd1,        4'd0,  1'b0);  // bad major
    send(ACT_GET,     16'hFF00,  24'd1,        4'd0,  1'b0);
    send(ACT_LOOKUP,  16'h0500,  24'd1,        4'd0,  1'b0);
    send(3'd6,        16'hFFFF,  24'hFFFFFF,   4'd15, 1'b1);
    send(3'd7,        16'h0000,  24'd0,        4'd0,  1'b0);
    // exhaust the free list
    for (int i = 0; i < 17; i++) send(ACT_GET, 16'h0001, 24'(i + 100), 4'd0, 1'b0);

    // random phases over several device counts
    foreach (dev_counts[k]) begin
      set_majors(dev_counts[k]);
      for (int i = 0; i < 130; i++) begin
        if (k == 2 && i == 40) long_hold = 1'b1;
        random_beat();
      end
    end
    // last part without any idling
    drain();
    quiet = 1'b1;
    for (int i = 0; i < 160; i++) random_beat();

    drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d request beats across %0d device-count settings,", n_items, n_cfg);
    $display("with a long result hold-off and drained pauses.");
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### buffer_cache_lru_manager.f
hw/rtl/bclru_pkg.sv
hw/rtl/bclru_if.sv
hw/rtl/bclru_cell.sv
hw/rtl/bclru_lru_cell.sv
hw/rtl/buffer_cache_lru_manager.sv
hw/rtl/bclru_checker.sv
tb/bclru_checker.sv
tb/buffer_cache_lru_manager_tb.sv
